### rtl/sntp_pkg.sv
// Shared types, constants and calendar tables for the SNTP reply time decoder.
package sntp_pkg;

  localparam int PACKET_BYTES = 48;
  localparam logic [5:0] POS_MAX = 6'd63;

  localparam logic [1:0] STATUS_OK    = 2'd0;
  localparam logic [1:0] STATUS_MODE  = 2'd1;
  localparam logic [1:0] STATUS_SHORT = 2'd2;
  localparam logic [1:0] STATUS_EARLY = 2'd3;

  localparam logic REG_EXPECTED_MODE  = 1'b0;
  localparam logic REG_SECONDS_OFFSET = 1'b1;

  localparam logic [2:0]  RESET_MODE   = 3'd4;
  localparam logic [5:0]  RESET_OFFSET = 6'd40;

  localparam logic [31:0] NTP_2013_SECONDS = 32'd3565987200;
  localparam logic [31:0] NTP_UNIX_SECONDS = 32'd2208988800;
  localparam logic [10:0] BASE_YEAR        = 11'd2013;

  // Reciprocals for the constant divisions, each exact over its input range.
  localparam logic [22:0] DAY_RECIP    = 23'd6362915;  // 2^32 / 675, rounded up
  localparam logic [12:0] HOUR_RECIP   = 13'd4661;     // 2^20 / 225, rounded up
  localparam logic [10:0] MINUTE_RECIP = 11'd1093;     // 2^14 / 15, rounded up
  localparam logic [13:0] WEEK_RECIP   = 14'd9363;     // 2^16 / 7, rounded up

  typedef struct packed {
    logic [1:0]  status;
    logic [31:0] secs;
  } stamp_t;

  // First day of year 2013 + idx, counted from 1 January 2013.
  function automatic logic [13:0] year_start(input logic [4:0] idx);
    logic [13:0] base;
    base = 14'(idx) * 14'd365;
    return base + 14'(idx >> 2);
  endfunction

  // Year 2013 + idx is a leap year when idx is 3 modulo 4 (2016 onward, to 2036).
  function automatic logic year_is_leap(input logic [4:0] idx);
    return idx[1:0] == 2'b11;
  endfunction

  // First day of month m within its year.
  function automatic logic [8:0] month_start(input logic [3:0] m, input logic leap);
    logic [8:0] d;
    case (m)
      4'd0:    d = 9'd0;
      4'd1:    d = 9'd31;
      4'd2:    d = 9'd59;
      4'd3:    d = 9'd90;
      4'd4:    d = 9'd120;
      4'd5:    d = 9'd151;
      4'd6:    d = 9'd181;
      4'd7:    d = 9'd212;
      4'd8:    d = 9'd243;
      4'd9:    d = 9'd273;
      4'd10:   d = 9'd304;
      4'd11:   d = 9'd334;
      default: d = 9'd0;
    endcase
    if (leap && m >= 4'd2) begin
      d = d + 9'd1;
    end
    return d;
  endfunction

endpackage

### rtl/sntp_byte_parser.sv
// Byte parser: configuration registers, packet position, mode capture and seconds assembly.
module sntp_byte_parser
  import sntp_pkg::*;
(
  input  logic       clk,
  input  logic       rst,
  input  logic       cfg_write,
  input  logic       cfg_index,
  input  logic [5:0] cfg_data,
  input  logic       in_valid,
  output logic       in_ready,
  input  logic [7:0] data_byte,
  input  logic       last_byte,
  output logic       stamp_valid,
  input  logic       stamp_ready,
  output stamp_t     stamp
);

  logic [2:0]  expected_mode;
  logic [5:0]  seconds_offset;
  logic [5:0]  byte_position;
  logic [2:0]  mode_bits;
  logic [31:0] seconds_accumulator;

  logic        accept;
  logic [2:0]  mode_next;
  logic [31:0] seconds_next;
  logic [6:0]  offset_end;
  logic        take_byte;
  logic        too_short;
  logic [1:0]  status_next;

  assign in_ready = !stamp_valid || stamp_ready;
  assign accept   = in_valid && in_ready;

  always_comb begin
    offset_end   = {1'b0, seconds_offset} + 7'd3;
    mode_next    = (byte_position == 6'd0) ? data_byte[2:0] : mode_bits;
    take_byte    = (byte_position != POS_MAX) && (byte_position >= seconds_offset) &&
                   ({1'b0, byte_position} <= offset_end);
    seconds_next = take_byte ? {seconds_accumulator[23:0], data_byte} : seconds_accumulator;
    // An offset whose last seconds byte would land at or past the saturated
    // position can never be filled, so such a packet is always short.
    too_short    = (byte_position < 6'(PACKET_BYTES - 1)) ||
                   ({1'b0, byte_position} < offset_end) || (offset_end >= 7'd63);
    if (mode_next != expected_mode) begin
      status_next = STATUS_MODE;
    end else if (too_short) begin
      status_next = STATUS_SHORT;
    end else begin
      status_next = STATUS_OK;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      expected_mode       <= RESET_MODE;
      seconds_offset      <= RESET_OFFSET;
      byte_position       <= 6'd0;
      mode_bits           <= 3'd0;
      seconds_accumulator <= 32'd0;
      stamp_valid         <= 1'b0;
    end else begin
      if (cfg_write) begin
        case (cfg_index)
          REG_EXPECTED_MODE:  expected_mode  <= cfg_data[2:0];
          REG_SECONDS_OFFSET: seconds_offset <= cfg_data;
          default:            ;
        endcase
      end
      if (accept) begin
        if (last_byte) begin
          byte_position       <= 6'd0;
          mode_bits           <= 3'd0;
          seconds_accumulator <= 32'd0;
        end else begin
          if (byte_position != POS_MAX) begin
            byte_position <= byte_position + 6'd1;
          end
          mode_bits           <= mode_next;
          seconds_accumulator <= seconds_next;
        end
      end
      if (in_ready) begin
        stamp_valid <= accept && last_byte;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept && last_byte) begin
      stamp.status <= status_next;
      stamp.secs   <= seconds_next;
    end
  end

endmodule

### rtl/sntp_date_pipe.sv
// Date pipeline: turns assembled NTP seconds into a UTC calendar date, time and Unix time.
module sntp_date_pipe
  import sntp_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic        stamp_valid,
  output logic        stamp_ready,
  input  stamp_t      stamp,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [1:0]  status,
  output logic [10:0] year,
  output logic [3:0]  month,
  output logic [4:0]  day_of_month,
  output logic [2:0]  weekday,
  output logic [4:0]  hour,
  output logic [5:0]  minute,
  output logic [5:0]  second,
  output logic [30:0] unix_time
);

  // Valid bits and ready chain; a stage takes a new entry when empty or moving on.
  logic v2, v3, v4, v5, v6, v7;
  logic r2, r3, r4, r5, r6, r7, r8;

  assign r8          = !out_valid || out_ready;
  assign r7          = !v7 || r8;
  assign r6          = !v6 || r7;
  assign r5          = !v5 || r6;
  assign r4          = !v4 || r5;
  assign r3          = !v3 || r4;
  assign r2          = !v2 || r3;
  assign stamp_ready = r2;

  // Stage payloads.
  logic [1:0]  st2, st3, st4, st5, st6, st7;
  logic [30:0] unix2, unix3, unix4, unix5, unix6, unix7;
  logic [29:0] el2, el3;
  logic [45:0] prod3;
  logic [13:0] days4, days5;
  logic [16:0] tod4, tod5;
  logic [4:0]  hour5, hour6, hour7;
  logic [4:0]  yi5, yi6, yi7;
  logic [13:0] w5;
  logic [11:0] q5;
  logic [11:0] rs6, rs7;
  logic [8:0]  doy6;
  logic        leap6;
  logic [2:0]  wd6, wd7;
  logic [5:0]  minute7;
  logic [3:0]  month7;
  logic [4:0]  dom7;

  // Combinational values between stages.
  logic [32:0] early_diff;
  logic [31:0] unix_diff;
  logic [13:0] days_q;
  logic [22:0] day_rem;
  logic [25:0] hour_prod;
  logic [4:0]  yi_next;
  logic [13:0] w_next;
  logic [27:0] week_prod;
  logic [16:0] rs_diff;
  logic [13:0] doy_diff;
  logic [13:0] wd_diff;
  logic [19:0] minute_prod;
  logic [3:0]  month_next;
  logic [8:0]  dom_diff;
  logic [11:0] second_diff;

  always_comb begin
    early_diff = {1'b0, stamp.secs} - {1'b0, NTP_2013_SECONDS};
    unix_diff  = stamp.secs - NTP_UNIX_SECONDS;

    days_q  = prod3[45:32];
    day_rem = el3[29:7] - 23'(days_q) * 23'd675;

    hour_prod = 26'(tod4[16:4]) * 26'(HOUR_RECIP);
    yi_next   = 5'd0;
    for (int i = 1; i < 24; i++) begin
      if (days4 >= year_start(5'(i))) begin
        yi_next = 5'(i);
      end
    end
    w_next    = days4 + 14'd2;
    week_prod = 28'(w_next) * 28'(WEEK_RECIP);

    rs_diff  = tod5 - 17'(hour5) * 17'd3600;
    doy_diff = days5 - year_start(yi5);
    wd_diff  = w5 - 14'(q5) * 14'd7;

    minute_prod = 20'(rs6[11:2]) * 20'(MINUTE_RECIP);
    month_next  = 4'd0;
    for (int m = 1; m < 12; m++) begin
      if (doy6 >= month_start(4'(m), leap6)) begin
        month_next = 4'(m);
      end
    end
    dom_diff = doy6 - month_start(month_next, leap6) + 9'd1;

    second_diff = rs7 - 12'(minute7) * 12'd60;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v2 <= 1'b0;
      v3 <= 1'b0;
      v4 <= 1'b0;
      v5 <= 1'b0;
      v6 <= 1'b0;
      v7 <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      if (r2) v2 <= stamp_valid;
      if (r3) v3 <= v2;
      if (r4) v4 <= v3;
      if (r5) v5 <= v4;
      if (r6) v6 <= v5;
      if (r7) v7 <= v6;
      if (r8) out_valid <= v7;
    end
  end

  always_ff @(posedge clk) begin
    if (r2) begin
      // A borrow out of the subtraction means the timestamp is before 2013.
      st2   <= (stamp.status == STATUS_OK && early_diff[32]) ? STATUS_EARLY : stamp.status;
      el2   <= early_diff[29:0];
      unix2 <= unix_diff[30:0];
    end
    if (r3) begin
      st3   <= st2;
      el3   <= el2;
      unix3 <= unix2;
      prod3 <= 46'(el2[29:7]) * 46'(DAY_RECIP);
    end
    if (r4) begin
      st4   <= st3;
      unix4 <= unix3;
      days4 <= days_q;
      tod4  <= {day_rem[9:0], el3[6:0]};
    end
    if (r5) begin
      st5   <= st4;
      unix5 <= unix4;
      days5 <= days4;
      tod5  <= tod4;
      hour5 <= hour_prod[24:20];
      yi5   <= yi_next;
      w5    <= w_next;
      q5    <= week_prod[27:16];
    end
    if (r6) begin
      st6   <= st5;
      unix6 <= unix5;
      hour6 <= hour5;
      yi6   <= yi5;
      rs6   <= rs_diff[11:0];
      doy6  <= doy_diff[8:0];
      leap6 <= year_is_leap(yi5);
      wd6   <= wd_diff[2:0];
    end
    if (r7) begin
      st7     <= st6;
      unix7   <= unix6;
      hour7   <= hour6;
      yi7     <= yi6;
      wd7     <= wd6;
      rs7     <= rs6;
      minute7 <= minute_prod[19:14];
      month7  <= month_next;
      dom7    <= dom_diff[4:0];
    end
    if (r8) begin
      status <= st7;
      if (st7 == STATUS_OK) begin
        year         <= BASE_YEAR + 11'(yi7);
        month        <= month7;
        day_of_month <= dom7;
        weekday      <= wd7;
        hour         <= hour7;
        minute       <= minute7;
        second       <= second_diff[5:0];
        unix_time    <= unix7;
      end else begin
        year         <= 11'd0;
        month        <= 4'd0;
        day_of_month <= 5'd0;
        weekday      <= 3'd0;
        hour         <= 5'd0;
        minute       <= 6'd0;
        second       <= 6'd0;
        unix_time    <= 31'd0;
      end
    end
  end

endmodule

### rtl/sntp_reply_time_decoder.sv
// Top level of the SNTP reply time decoder: byte parser followed by the date pipeline.
// Takes one packet byte per cycle while in_ready is high; a request that is not the last byte gives no result.
// A last byte gives its result through the parser's stamp register, the date stages and the output register.
// Throughput is one byte per cycle while out_ready keeps up; the six date stages and the output register stall on it.
// Synchronous reset clears position, mode, seconds and all valid bits, and loads
// expected mode 4 and seconds offset 40.
module sntp_reply_time_decoder
  import sntp_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic        cfg_write,
  input  logic        cfg_index,
  input  logic [5:0]  cfg_data,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [7:0]  data_byte,
  input  logic        last_byte,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [1:0]  status,
  output logic [10:0] year,
  output logic [3:0]  month,
  output logic [4:0]  day_of_month,
  output logic [2:0]  weekday,
  output logic [4:0]  hour,
  output logic [5:0]  minute,
  output logic [5:0]  second,
  output logic [30:0] unix_time
);

  logic   stamp_valid;
  logic   stamp_ready;
  stamp_t stamp;

  sntp_byte_parser u_parser (
    .clk         (clk),
    .rst         (rst),
    .cfg_write   (cfg_write),
    .cfg_index   (cfg_index),
    .cfg_data    (cfg_data),
    .in_valid    (in_valid),
    .in_ready    (in_ready),
    .data_byte   (data_byte),
    .last_byte   (last_byte),
    .stamp_valid (stamp_valid),
    .stamp_ready (stamp_ready),
    .stamp       (stamp)
  );

  sntp_date_pipe u_date (
    .clk          (clk),
    .rst          (rst),
    .stamp_valid  (stamp_valid),
    .stamp_ready  (stamp_ready),
    .stamp        (stamp),
    .out_valid    (out_valid),
    .out_ready    (out_ready),
    .status       (status),
    .year         (year),
    .month        (month),
    .day_of_month (day_of_month),
    .weekday      (weekday),
    .hour         (hour),
    .minute       (minute),
    .second       (second),
    .unix_time    (unix_time)
  );

  // With the output register empty the whole pipeline can move, so bytes are taken.
  a_ready_when_drained: assert property (@(posedge clk) disable iff (rst)
    !out_valid |-> in_ready)
    else $error("input stalled while the output register is empty");

  a_failed_fields_zero: assert property (@(posedge clk) disable iff (rst)
    out_valid && status != STATUS_OK |->
      year == 11'd0 && day_of_month == 5'd0 && unix_time == 31'd0 && hour == 5'd0)
    else $error("failed request carries nonzero date fields");

  a_date_in_range: assert property (@(posedge clk) disable iff (rst)
    out_valid && status == STATUS_OK |->
      year >= 11'd2013 && year <= 11'd2036 && month < 4'd12 && day_of_month != 5'd0 &&
      weekday < 3'd7)
    else $error("calendar date out of range");

  a_time_in_range: assert property (@(posedge clk) disable iff (rst)
    out_valid && status == STATUS_OK |->
      hour < 5'd24 && minute < 6'd60 && second < 6'd60)
    else $error("time of day out of range");

endmodule
